// ----- sv/s2dec_pkg.sv -----
package s2dec_pkg;

  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // Double-dabble correction: a digit of five or more gets three added
  // before the shift so that it carries correctly into the next digit.
  function automatic digit_t dabble_adjust(input digit_t d);
    digit_t res;
    res = d;
    if (d >= digit_t'(5)) begin
      res = d + digit_t'(3);
    end
    return res;
  endfunction

endpackage

// ----- sv/s2dec_bcd.sv -----
module s2dec_bcd
  import s2dec_pkg::*;
#(
  parameter int NDIG  = 10,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             clear,
  input  logic             shift_en,
  input  logic             bit_in,
  input  logic [IDX_W-1:0] digit_sel,
  output digit_t           digit_out,
  output logic [IDX_W-1:0] lead_idx
);

  localparam int BCD_W = NDIG * DIGIT_W;

  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] adj;
  logic [BCD_W-1:0] bcd_nxt;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*DIGIT_W +: DIGIT_W] = dabble_adjust(bcd_r[i*DIGIT_W +: DIGIT_W]);
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    if (clear) begin
      bcd_nxt = '0;
    end else if (shift_en) begin
      bcd_nxt = {adj[BCD_W-2:0], bit_in};
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
  end

  // Position of the most significant nonzero digit; zero maps to digit 0.
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] != '0) begin
        lead_idx = IDX_W'(i);
      end
    end
  end

  assign digit_out = bcd_r[digit_sel*DIGIT_W +: DIGIT_W];

endmodule

// ----- sv/signed_int_to_decimal_ascii_top.sv -----
// Channel  Direction  Ports                                Meaning
// in       input      in_valid, in_ready, in_value         one signed integer per item
// out      output     out_valid, out_ready, out_character, one ASCII character per item,
//                     out_last                             last set on the final one
//
// An integer is loaded, its VALUE_WIDTH magnitude bits are shifted bit-serially through
// double-dabble in the BCD shift register, and then characters are emitted one per cycle
// while the output slot is free. Characters leave through a registered output slot, and
// a stalled out_ready holds the conversion in its emit phase. A new integer is taken
// once the final character sits in the output register. Reset clears only control state.
module signed_int_to_decimal_ascii_top
  import s2dec_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      out_character,
  output logic                   out_last
);

  // Digits in 2^(VALUE_WIDTH-1); 1233/4096 approximates log10(2).
  localparam int NDIG  = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
  localparam int IDX_W = $clog2(NDIG);
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic                   first_r, first_nxt;
  logic [CNT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]       dig_idx_r, dig_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  char_t                  out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   slot_free;
  logic [IDX_W-1:0]       cur_idx;
  logic [IDX_W-1:0]       lead_idx;
  digit_t                 digit;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cur_idx   = first_r ? lead_idx : dig_idx_r;

  s2dec_bcd #(
    .NDIG  (NDIG),
    .IDX_W (IDX_W)
  ) u_bcd (
    .clk       (clk),
    .clear     (accept),
    .shift_en  (state_r == ST_CONV),
    .bit_in    (mag_r[VALUE_WIDTH-1]),
    .digit_sel (cur_idx),
    .digit_out (digit),
    .lead_idx  (lead_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    first_nxt     = first_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_idx_nxt   = dig_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt     = in_value[VALUE_WIDTH-1];
          mag_nxt     = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
          bit_cnt_nxt = '0;
          first_nxt   = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt     = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            // The sign goes out first, ahead of the digits.
            out_char_nxt = CHAR_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = CHAR_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digit};
            out_last_nxt = (cur_idx == '0);
            first_nxt    = 1'b0;
            dig_idx_nxt  = cur_idx - 1'b1;
            if (cur_idx == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    first_r    <= first_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_idx_r  <= dig_idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule
